// ===== sv/lpd_pkg.sv =====
// ----------------------------------------------------------------------------
// lpd_pkg: shared constants and types for the lift PD position controller
// Field widths, register indexes, reset values and the zone scaling constant.
// ----------------------------------------------------------------------------
`default_nettype none

package lpd_pkg;

	localparam int POS_WIDTH_DEF = 16;
	localparam int DT_W          = 10;
	localparam int GAIN_W        = 16;
	localparam int MAXH_W        = 15;
	localparam int ZONE_W        = 16;
	localparam int FP_W          = 7;
	localparam int DRIVE_W       = 8;
	localparam int Q_FRAC        = 8;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 16;

	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P_UP   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P_DOWN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D_UP   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D_DOWN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_HEIGHT  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ZONE_TOP    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ZONE_BOTTOM = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_POWER  = 3'd7;

	localparam logic [GAIN_W-1:0]        GAIN_P_UP_RST   = 16'd69;
	localparam logic [GAIN_W-1:0]        GAIN_P_DOWN_RST = 16'd44;
	localparam logic [GAIN_W-1:0]        GAIN_D_UP_RST   = 16'd0;
	localparam logic [GAIN_W-1:0]        GAIN_D_DOWN_RST = 16'd0;
	localparam logic [MAXH_W-1:0]        MAX_HEIGHT_RST  = 15'd1000;
	localparam logic signed [ZONE_W-1:0] ZONE_TOP_RST    = 16'sd900;
	localparam logic signed [ZONE_W-1:0] ZONE_BOTTOM_RST = 16'sd100;
	localparam logic [FP_W-1:0]          FULL_POWER_RST  = 7'd100;

	// floor(x * 5 / 11) == (x * 3725) >> 13 for 0 <= x <= 127
	localparam int               ZONE_MUL_W = 12;
	localparam logic [ZONE_MUL_W-1:0] ZONE_MUL = 12'd3725;
	localparam int               ZONE_SHIFT = 13;

	typedef struct packed {
		logic busy;
		logic done;
	} lpd_div_stat_t;

endpackage

`default_nettype wire

// ===== sv/lpd_if.sv =====
// ----------------------------------------------------------------------------
// lpd_if: channel interfaces of the lift PD position controller
// Tick channel (target, position, elapsed time) and result channel (drive).
// ----------------------------------------------------------------------------
`default_nettype none

interface lpd_tick_if #(
	parameter int POS_WIDTH = lpd_pkg::POS_WIDTH_DEF
) ();
	logic                          valid;
	logic                          ready;
	logic signed [POS_WIDTH-1:0]   target;
	logic signed [POS_WIDTH-1:0]   position;
	logic [lpd_pkg::DT_W-1:0]      elapsed_ms;

	modport source (output valid, output target, output position, output elapsed_ms,
		input ready);
	modport sink (input valid, input target, input position, input elapsed_ms,
		output ready);
endinterface

interface lpd_result_if ();
	logic                             valid;
	logic                             ready;
	logic signed [lpd_pkg::DRIVE_W-1:0] drive;
	logic                             zone_scaled;

	modport source (output valid, output drive, output zone_scaled, input ready);
	modport sink (input valid, input drive, input zone_scaled, output ready);
endinterface

`default_nettype wire

// ===== sv/lift_pd_position_controller.sv =====
// ----------------------------------------------------------------------------
// lift_pd_position_controller: PD position loop for a lift
// Clamps the target, forms error and rate, applies Q8.8 gains, saturates the
// drive and reduces it inside the end buffer zones.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake     | payload
//  tick     | in  | valid / ready | target, position, elapsed_ms
//  result   | out | valid / ready | drive, zone_scaled
//  cfg      | in  | cfg_wr_en     | cfg_index, cfg_wr_data
//
//  The divider forms the rate one quotient bit per cycle; it is skipped when
//  elapsed_ms is zero. tick.ready is high only while the sequencer is idle.
//  The result sits in an output register, so a stalled result does not hold
//  off the next item until its own result is ready. Reset clears the
//  previous error and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module lift_pd_position_controller #(
	parameter int POS_WIDTH = lpd_pkg::POS_WIDTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_wr_en,
	input  wire logic [lpd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [lpd_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
	lpd_tick_if.sink                              tick,
	lpd_result_if.source                          result
);
	import lpd_pkg::*;

	localparam int ERR_W = POS_WIDTH + 2;
	localparam int CMP_W = ((POS_WIDTH > ZONE_W) ? POS_WIDTH : ZONE_W) + 1;
	localparam int MUL_W = GAIN_W + 1 + ERR_W;
	localparam int ACC_W = MUL_W + 1;
	localparam int QI_W  = ACC_W - Q_FRAC;
	localparam int ZP_W  = FP_W + ZONE_MUL_W;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_ERR  = 4'd1;
	localparam logic [3:0] ST_DIFF = 4'd2;
	localparam logic [3:0] ST_DIV  = 4'd3;
	localparam logic [3:0] ST_MULP = 4'd4;
	localparam logic [3:0] ST_MULD = 4'd5;
	localparam logic [3:0] ST_SUM  = 4'd6;
	localparam logic [3:0] ST_SAT  = 4'd7;
	localparam logic [3:0] ST_ZONE = 4'd8;

	// configuration
	logic [GAIN_W-1:0]        gain_p_up_q;
	logic [GAIN_W-1:0]        gain_p_down_q;
	logic [GAIN_W-1:0]        gain_d_up_q;
	logic [GAIN_W-1:0]        gain_d_down_q;
	logic [MAXH_W-1:0]        max_height_q;
	logic signed [ZONE_W-1:0] zone_top_q;
	logic signed [ZONE_W-1:0] zone_bottom_q;
	logic [FP_W-1:0]          full_power_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_up_q   <= GAIN_P_UP_RST;
			gain_p_down_q <= GAIN_P_DOWN_RST;
			gain_d_up_q   <= GAIN_D_UP_RST;
			gain_d_down_q <= GAIN_D_DOWN_RST;
			max_height_q  <= MAX_HEIGHT_RST;
			zone_top_q    <= ZONE_TOP_RST;
			zone_bottom_q <= ZONE_BOTTOM_RST;
			full_power_q  <= FULL_POWER_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_GAIN_P_UP:   gain_p_up_q   <= cfg_wr_data[GAIN_W-1:0];
				REG_GAIN_P_DOWN: gain_p_down_q <= cfg_wr_data[GAIN_W-1:0];
				REG_GAIN_D_UP:   gain_d_up_q   <= cfg_wr_data[GAIN_W-1:0];
				REG_GAIN_D_DOWN: gain_d_down_q <= cfg_wr_data[GAIN_W-1:0];
				REG_MAX_HEIGHT:  max_height_q  <= cfg_wr_data[MAXH_W-1:0];
				REG_ZONE_TOP:    zone_top_q    <= $signed(cfg_wr_data[ZONE_W-1:0]);
				REG_ZONE_BOTTOM: zone_bottom_q <= $signed(cfg_wr_data[ZONE_W-1:0]);
				REG_FULL_POWER:  full_power_q  <= cfg_wr_data[FP_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer and datapath
	logic [3:0]                  state_q;
	logic signed [POS_WIDTH-1:0] tgt_q;
	logic signed [POS_WIDTH-1:0] pos_q;
	logic [DT_W-1:0]             dt_q;
	logic signed [ERR_W-1:0]     err_q;
	logic signed [ERR_W-1:0]     prev_err_q;
	logic signed [ERR_W-1:0]     rate_q;
	logic                        up_q;
	logic signed [MUL_W-1:0]     prod_q;
	logic signed [ACC_W-1:0]     acc_q;
	logic signed [DRIVE_W-1:0]   sat_q;
	logic                        out_valid_q;
	logic signed [DRIVE_W-1:0]   out_drive_q;
	logic                        out_zone_q;

	logic                        tick_acc;
	logic signed [CMP_W-1:0]     tgt_x;
	logic signed [CMP_W-1:0]     maxh_x;
	logic signed [CMP_W-1:0]     tgt_c;
	logic signed [ERR_W-1:0]     diff;
	logic                        div_start;
	logic signed [ERR_W-1:0]     div_quo;
	lpd_div_stat_t               div_stat;
	logic [GAIN_W-1:0]           mul_a;
	logic signed [ERR_W-1:0]     mul_b;
	logic signed [MUL_W-1:0]     prod;
	logic signed [ACC_W-1:0]     acc_t;
	logic signed [QI_W-1:0]      acc_i;
	logic signed [QI_W-1:0]      fp_x;
	logic signed [DRIVE_W-1:0]   sat_d;
	logic signed [CMP_W-1:0]     pos_x;
	logic signed [CMP_W-1:0]     top_x;
	logic signed [CMP_W-1:0]     bot_x;
	logic                        in_zone;
	logic [FP_W-1:0]             sat_mag;
	logic [ZP_W-1:0]             zone_prod;
	logic [DRIVE_W-1:0]          zone_mag;
	logic signed [DRIVE_W-1:0]   zone_drive;
	logic                        out_load;

	assign tick.ready = (state_q == ST_IDLE);
	assign tick_acc   = tick.valid && tick.ready;

	// target clamp to 0..max_height
	assign tgt_x  = CMP_W'(tick.target);
	assign maxh_x = $signed(CMP_W'(max_height_q));
	always_comb begin
		if (tgt_x < 0) begin
			tgt_c = '0;
		end else if (tgt_x > maxh_x) begin
			tgt_c = maxh_x;
		end else begin
			tgt_c = tgt_x;
		end
	end

	assign diff      = err_q - prev_err_q;
	assign div_start = (state_q == ST_DIFF) && (dt_q != '0) && !div_stat.busy;

	lpd_div #(
		.NUM_W (ERR_W),
		.DEN_W (DT_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (diff),
		.den    (dt_q),
		.quo    (div_quo),
		.stat   (div_stat)
	);

	// one multiplier, P term then D term
	always_comb begin
		if (state_q == ST_MULP) begin
			mul_a = up_q ? gain_p_up_q : gain_p_down_q;
			mul_b = err_q;
		end else begin
			mul_a = up_q ? gain_d_up_q : gain_d_down_q;
			mul_b = rate_q;
		end
	end
	assign prod = $signed({1'b0, mul_a}) * mul_b;

	// Q8.8 to integer toward zero, then saturate
	assign acc_t = acc_q[ACC_W-1] ? ((acc_q + ACC_W'((1 << Q_FRAC) - 1)) >>> Q_FRAC)
		: (acc_q >>> Q_FRAC);
	assign acc_i = acc_t[QI_W-1:0];
	assign fp_x  = $signed(QI_W'(full_power_q));
	always_comb begin
		if (acc_i > fp_x) begin
			sat_d = DRIVE_W'(fp_x);
		end else if (acc_i < -fp_x) begin
			sat_d = DRIVE_W'(-fp_x);
		end else begin
			sat_d = DRIVE_W'(acc_i);
		end
	end

	// end buffer zones
	assign pos_x   = CMP_W'(pos_q);
	assign top_x   = CMP_W'(zone_top_q);
	assign bot_x   = CMP_W'(zone_bottom_q);
	assign in_zone = ((sat_q > 0) && (pos_x > top_x)) || ((sat_q < 0) && (pos_x < bot_x));
	assign sat_mag = sat_q[DRIVE_W-1] ? FP_W'(-sat_q) : FP_W'(sat_q);
	assign zone_prod  = ZP_W'(sat_mag) * ZP_W'(ZONE_MUL);
	assign zone_mag   = DRIVE_W'(zone_prod >> ZONE_SHIFT);
	assign zone_drive = sat_q[DRIVE_W-1] ? $signed(-zone_mag) : $signed(zone_mag);

	assign out_load = (state_q == ST_ZONE) && (!out_valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			prev_err_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (tick_acc) state_q <= ST_ERR;
				end
				ST_ERR:  state_q <= ST_DIFF;
				ST_DIFF: begin
					prev_err_q <= err_q;
					state_q    <= (dt_q == '0) ? ST_MULP : ST_DIV;
				end
				ST_DIV: begin
					if (div_stat.done) state_q <= ST_MULP;
				end
				ST_MULP: state_q <= ST_MULD;
				ST_MULD: state_q <= ST_SUM;
				ST_SUM:  state_q <= ST_SAT;
				ST_SAT:  state_q <= ST_ZONE;
				ST_ZONE: begin
					if (out_load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tick_acc) begin
			tgt_q <= tgt_c[POS_WIDTH-1:0];
			pos_q <= tick.position;
			dt_q  <= tick.elapsed_ms;
		end
		if (state_q == ST_ERR) begin
			err_q <= ERR_W'(tgt_q) - ERR_W'(pos_q);
		end
		if (state_q == ST_DIFF) begin
			up_q   <= (err_q > 0);
			rate_q <= '0;
		end
		if (state_q == ST_DIV && div_stat.done) begin
			rate_q <= div_quo;
		end
		if (state_q == ST_MULP) begin
			acc_q <= ACC_W'(prod);
		end
		if (state_q == ST_MULD) begin
			prod_q <= prod;
		end
		if (state_q == ST_SUM) begin
			acc_q <= acc_q + ACC_W'(prod_q);
		end
		if (state_q == ST_SAT) begin
			sat_q <= sat_d;
		end
		if (out_load) begin
			out_drive_q <= in_zone ? zone_drive : sat_q;
			out_zone_q  <= in_zone;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.drive       = out_drive_q;
	assign result.zone_scaled = out_zone_q;

endmodule

`default_nettype wire

// ===== sv/lpd_div.sv =====
// ----------------------------------------------------------------------------
// lpd_div: iterative signed-by-unsigned divider
// Restoring division, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module lpd_div #(
	parameter int NUM_W = lpd_pkg::POS_WIDTH_DEF + 2,
	parameter int DEN_W = lpd_pkg::DT_W
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic signed [NUM_W-1:0]   num,
	input  wire logic [DEN_W-1:0]          den,
	output logic signed [NUM_W-1:0]        quo,
	output lpd_pkg::lpd_div_stat_t         stat
);
	import lpd_pkg::*;

	localparam int CNT_W = $clog2(NUM_W);

	logic             busy_q;
	logic             fix_q;
	logic             done_q;
	logic             neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] quo_q;

	logic [NUM_W-1:0] mag;
	logic [DEN_W:0]   shifted;
	logic [DEN_W+1:0] trial;
	logic             ge;

	assign mag     = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
	assign shifted = {rem_q, quo_q[NUM_W-1]};
	assign trial   = {1'b0, shifted} - {2'b00, den_q};
	assign ge      = ~trial[DEN_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fix_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q && !fix_q) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == '0) begin
				busy_q <= 1'b0;
				fix_q  <= 1'b1;
			end else if (fix_q) begin
				fix_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q && !fix_q) begin
			quo_q <= mag;
			rem_q <= '0;
			den_q <= den;
			neg_q <= num[NUM_W-1];
			cnt_q <= CNT_W'(NUM_W - 1);
		end else if (busy_q) begin
			rem_q <= ge ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
			cnt_q <= cnt_q - CNT_W'(1);
		end else if (fix_q) begin
			quo_q <= neg_q ? (~quo_q + NUM_W'(1)) : quo_q;
		end
	end

	assign quo       = $signed(quo_q);
	assign stat.busy = busy_q | fix_q;
	assign stat.done = done_q;

endmodule

`default_nettype wire

// ===== sv/lpd_checker.sv =====
// ----------------------------------------------------------------------------
// lpd_checker: port-level checks for the lift PD position controller
// Watches the tick and result channels; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lpd_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              tick_valid,
	input wire logic                              tick_ready,
	input wire logic                              result_valid,
	input wire logic                              result_ready,
	input wire logic signed [lpd_pkg::DRIVE_W-1:0] drive,
	input wire logic                              zone_scaled
);
	import lpd_pkg::*;

	// a result waits until taken
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result dropped before it was taken");

	// one item in work at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		tick_valid && tick_ready |=> !tick_ready)
		else $error("tick accepted while an item is in work");

	// saturated drive never reaches the most negative code
	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> drive != -8'sd128)
		else $error("drive outside saturation range");

	// zone scaling caps the magnitude at 127 * 5 / 11
	a_zone_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && zone_scaled |-> (drive <= 8'sd57) && (drive >= -8'sd57))
		else $error("zone scaled drive too large");

endmodule

bind lift_pd_position_controller lpd_checker u_lpd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.tick_valid   (tick.valid),
	.tick_ready   (tick.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.drive        (result.drive),
	.zone_scaled  (result.zone_scaled)
);

`default_nettype wire

// ===== sim/lpd_drive_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lpd_drive_checker: drive predictor and result checker for the lift PD loop
// Watches the register port and both channels, keeps its own copy of the
// gains, limits and previous error, predicts drive and zone flag for every
// accepted tick, and compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module lpd_drive_checker import lpd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wr_data,
	lpd_tick_if                   tick,
	lpd_result_if                 result,
	output int                    errors,
	output int                    pending,
	output int                    checked,
	output int                    zone_hits
);

	localparam longint ZONE_NUM = 5;
	localparam longint ZONE_DEN = 11;

	typedef struct packed {
		logic signed [DRIVE_W-1:0] drive;
		logic                      zone_scaled;
	} drive_res_t;

	logic [GAIN_W-1:0]          kp_up, kp_dn, kd_up, kd_dn;
	logic [MAXH_W-1:0]          max_h;
	logic signed [ZONE_W-1:0]   z_top, z_bot;
	logic [FP_W-1:0]            fp_lim;
	logic signed [POS_WIDTH_DEF+1:0] prev_err;

	drive_res_t drive_q[$];
	int err_cnt   = 0;
	int chk_cnt   = 0;
	int scale_cnt = 0;

	function automatic drive_res_t predict_drive(
			input logic signed [POS_WIDTH_DEF-1:0] tgt_in,
			input logic signed [POS_WIDTH_DEF-1:0] pos_in,
			input logic [DT_W-1:0] dt, output longint err);
		longint tgt, pos, rate, acc, power, lim;
		drive_res_t res;
		tgt = tgt_in;
		pos = pos_in;
		lim = longint'(fp_lim);
		if (tgt < 0)
			tgt = 0;
		else if (tgt > longint'(max_h))
			tgt = longint'(max_h);
		err  = tgt - pos;
		rate = (dt == '0) ? 0 : (err - longint'(prev_err)) / longint'(dt);
		if (err > 0)
			acc = longint'(kp_up) * err + longint'(kd_up) * rate;
		else
			acc = longint'(kp_dn) * err + longint'(kd_dn) * rate;
		power = acc / 256;
		if (power > lim)
			power = lim;
		else if (power < -lim)
			power = -lim;
		res.zone_scaled = 1'b0;
		if ((power > 0 && pos > longint'(z_top)) || (power < 0 && pos < longint'(z_bot))) begin
			power = power * ZONE_NUM / ZONE_DEN;
			res.zone_scaled = 1'b1;
		end
		res.drive = power[DRIVE_W-1:0];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		drive_res_t want;
		longint     new_err;
		if (!arst_n) begin
			kp_up    = GAIN_P_UP_RST;
			kp_dn    = GAIN_P_DOWN_RST;
			kd_up    = GAIN_D_UP_RST;
			kd_dn    = GAIN_D_DOWN_RST;
			max_h    = MAX_HEIGHT_RST;
			z_top    = ZONE_TOP_RST;
			z_bot    = ZONE_BOTTOM_RST;
			fp_lim   = FULL_POWER_RST;
			prev_err = '0;
			drive_q.delete();
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_GAIN_P_UP:   kp_up  = cfg_wr_data;
					REG_GAIN_P_DOWN: kp_dn  = cfg_wr_data;
					REG_GAIN_D_UP:   kd_up  = cfg_wr_data;
					REG_GAIN_D_DOWN: kd_dn  = cfg_wr_data;
					REG_MAX_HEIGHT:  max_h  = cfg_wr_data[MAXH_W-1:0];
					REG_ZONE_TOP:    z_top  = cfg_wr_data;
					REG_ZONE_BOTTOM: z_bot  = cfg_wr_data;
					REG_FULL_POWER:  fp_lim = cfg_wr_data[FP_W-1:0];
					default: ;
				endcase
			end
			if (result.valid && result.ready) begin
				if (drive_q.size() == 0) begin
					$display("%0t: result with no tick outstanding: drive %0d, zone %0b",
						$time, result.drive, result.zone_scaled);
					err_cnt++;
				end else begin
					want = drive_q.pop_front();
					chk_cnt++;
					if (want.zone_scaled)
						scale_cnt++;
					if (result.drive !== want.drive) begin
						$display("%0t: drive mismatch: expected %0d, got %0d",
							$time, want.drive, result.drive);
						err_cnt++;
					end
					if (result.zone_scaled !== want.zone_scaled) begin
						$display("%0t: zone_scaled mismatch: expected %0b, got %0b",
							$time, want.zone_scaled, result.zone_scaled);
						err_cnt++;
					end
				end
			end
			if (tick.valid && tick.ready) begin
				drive_q.push_back(predict_drive(tick.target, tick.position,
					tick.elapsed_ms, new_err));
				prev_err = new_err[POS_WIDTH_DEF+1:0];
			end
		end
		errors    <= err_cnt;
		pending   <= drive_q.size();
		checked   <= chk_cnt;
		zone_hits <= scale_cnt;
	end

endmodule

// ===== sim/tb_lift_pd_position_controller.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lift_pd_position_controller: testbench of the lift PD position loop
// Drives directed and random control ticks under a series of register
// settings, extremes included, mostly with random idling on both channels; the
// drive checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_lift_pd_position_controller;
	import lpd_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 64;

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  cfg_wr_en   = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index   = '0;
	logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

	int send_idle_pct = 36;
	int recv_idle_pct = 88;
	int idle_cycles   = 0;
	int ticks_sent    = 0;
	int settings_used = 1;
	int cur_mh        = 1000;
	int cur_zt        = 900;
	int cur_zb        = 100;
	int errors, pending, checked, zone_hits;

	lpd_tick_if #(.POS_WIDTH(POS_WIDTH_DEF)) tick_ch ();
	lpd_result_if result_ch ();

	lift_pd_position_controller #(.POS_WIDTH(POS_WIDTH_DEF)) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wr_data (cfg_wr_data),
		.tick        (tick_ch),
		.result      (result_ch)
	);

	lpd_drive_checker drive_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wr_data (cfg_wr_data),
		.tick        (tick_ch),
		.result      (result_ch),
		.errors      (errors),
		.pending     (pending),
		.checked     (checked),
		.zone_hits   (zone_hits)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((tick_ch.valid && tick_ch.ready) || (result_ch.valid && result_ch.ready)
					|| cfg_wr_en) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no item moved for %0d cycles", $time, idle_cycles);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic send_tick(input int tgt, input int pos, input int dt);
		while ($urandom_range(99) < send_idle_pct) begin
			tick_ch.valid      <= 1'b0;
			tick_ch.target     <= 16'($urandom);
			tick_ch.position   <= 16'($urandom);
			tick_ch.elapsed_ms <= 10'($urandom);
			@(posedge clk);
		end
		tick_ch.valid      <= 1'b1;
		tick_ch.target     <= 16'(tgt);
		tick_ch.position   <= 16'(pos);
		tick_ch.elapsed_ms <= 10'(dt);
		@(posedge clk);
		while (!tick_ch.ready)
			@(posedge clk);
		ticks_sent++;
	endtask

	task automatic wait_drained();
		tick_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
		cfg_wr_en   <= 1'b1;
		cfg_index   <= idx;
		cfg_wr_data <= CFG_DATA_W'(val);
		@(posedge clk);
	endtask

	task automatic load_setting(input int kpu, input int kpd, input int kdu, input int kdd,
			input int mh, input int zt, input int zb, input int fp);
		write_reg(REG_GAIN_P_UP, kpu);
		write_reg(REG_GAIN_P_DOWN, kpd);
		write_reg(REG_GAIN_D_UP, kdu);
		write_reg(REG_GAIN_D_DOWN, kdd);
		write_reg(REG_MAX_HEIGHT, mh);
		write_reg(REG_ZONE_TOP, zt);
		write_reg(REG_ZONE_BOTTOM, zb);
		write_reg(REG_FULL_POWER, fp);
		cfg_wr_en <= 1'b0;
		cur_mh = mh & 32'h7FFF;
		cur_zt = zt;
		cur_zb = zb;
		settings_used++;
	endtask

	task automatic load_random_setting();
		int gains[4];
		int mh, zt, zb, fp;
		foreach (gains[g])
			gains[g] = ($urandom_range(3) == 0) ? int'($urandom_range(65535))
				: int'($urandom_range(1536));
		mh = ($urandom_range(4) == 0) ? int'($urandom_range(32767))
			: int'($urandom_range(100, 3000));
		if ($urandom_range(5) == 0) begin
			zt = int'($urandom_range(65535)) - 32768;
			zb = int'($urandom_range(65535)) - 32768;
		end else begin
			zt = int'($urandom_range(mh / 2, mh));
			zb = int'($urandom_range(mh / 2));
		end
		fp = int'($urandom_range(127)) | (int'($urandom_range(511)) << 7);
		load_setting(gains[0], gains[1], gains[2], gains[3],
			mh | (int'($urandom_range(1)) << 15), zt, zb, fp);
	endtask

	// mostly closed-loop runs toward a moving goal, the rest raw noise and corners
	task automatic run_batch(input int n);
		int k, sel, goal, pos, dt;
		int tgt_pick[4];
		int pos_pick[6];
		int dt_pick[3];
		goal = int'($urandom_range(cur_mh));
		pos  = 0;
		for (k = 0; k < n; k++) begin
			sel = int'($urandom_range(99));
			if (sel < 70) begin
				if ($urandom_range(15) == 0)
					goal = ($urandom_range(7) == 0) ? -int'($urandom_range(200))
						: int'($urandom_range(cur_mh));
				pos = pos + (goal - pos) / 4 + int'($urandom_range(20)) - 10;
				dt  = ($urandom_range(9) == 0) ? 0 : int'($urandom_range(1, 40));
				send_tick(goal, pos, dt);
			end else if (sel < 90) begin
				send_tick(int'($urandom), int'($urandom), int'($urandom));
			end else begin
				tgt_pick = '{-32768, 32767, 0, cur_mh};
				pos_pick = '{-32768, 32767, cur_zt, cur_zt + 1, cur_zb, cur_zb - 1};
				dt_pick  = '{0, 1, 1023};
				send_tick(tgt_pick[$urandom_range(3)], pos_pick[$urandom_range(5)],
					dt_pick[$urandom_range(2)]);
			end
		end
	endtask

	initial begin
		tick_ch.valid      = 1'b0;
		tick_ch.target     = '0;
		tick_ch.position   = '0;
		tick_ch.elapsed_ms = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: clamps, saturation, zone edges, zero drive in a zone
		send_tick(-32768, 0, 0);
		send_tick(32767, -32768, 1023);
		send_tick(0, 32767, 1);
		send_tick(1000, 950, 5);
		send_tick(1000, 900, 5);
		send_tick(1000, 901, 5);
		send_tick(0, 100, 5);
		send_tick(0, 99, 5);
		send_tick(950, 949, 7);
		send_tick(0, 1, 3);
		send_tick(500, 500, 0);
		send_tick(1, 0, 2);
		wait_drained();

		// derivative gains on, full power 127 with upper data bits set
		load_setting(16'h0100, 16'h0080, 16'h0400, 16'h0300, 1000, 900, 100, 16'hFF7F);
		send_tick(600, 400, 0);
		send_tick(600, 100, 1);
		send_tick(100, 900, 1);
		send_tick(100, 90, 1023);
		send_tick(32767, -32768, 1);
		send_tick(-1, 32767, 1);
		send_tick(1000, 1000, 3);
		wait_drained();

		load_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32767, -32768, 16'hFFFF);
		run_batch(150);
		wait_drained();
		load_random_setting();
		run_batch(150);
		wait_drained();

		send_idle_pct = 88;
		recv_idle_pct = 36;
		load_setting(0, 0, 0, 0, 0, -32768, 32767, 0);
		run_batch(100);
		wait_drained();
		load_random_setting();
		run_batch(150);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		load_random_setting();
		run_batch(175);
		wait_drained();
		load_random_setting();
		run_batch(175);
		wait_drained();

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d control ticks across %0d register settings, defaults included.",
			ticks_sent, settings_used);
		$display("Checked %0d drive results, %0d of them reduced in a buffer zone.",
			checked, zone_hits);
		if (errors == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== lift_pd_position_controller.f =====
sv/lpd_pkg.sv
sv/lpd_if.sv
sv/lpd_div.sv
sv/lift_pd_position_controller.sv
sv/lpd_checker.sv
sim/lpd_drive_checker.sv
sim/tb_lift_pd_position_controller.sv
